// ===== rtl/core/nrg_pkg.sv =====
// ----------------------------------------------------------------------------
// nrg_pkg
// Shared codes, constants and controller/datapath link types for the
// nonce replay guard.
// ----------------------------------------------------------------------------
package nrg_pkg;

  localparam logic [2:0] REQ_CHECK = 3'd0;
  localparam logic [2:0] REQ_DFAIL = 3'd1;
  localparam logic [2:0] REQ_DOK   = 3'd2;
  localparam logic [2:0] REQ_ISSUE = 3'd3;
  localparam logic [2:0] REQ_START = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_SESSION  = 3'd1;
  localparam logic [2:0] ST_ID_MISMATCH = 3'd2;
  localparam logic [2:0] ST_WINDOW      = 3'd3;
  localparam logic [2:0] ST_REPLAY      = 3'd4;

  localparam logic [63:0] WIN_HALF  = 64'd32;
  localparam logic [63:0] WIN_SPAN  = 64'd64;
  localparam logic [1:0]  FAIL_LAST = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_SCAN,
    S_APPLY
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan_clear;
    logic scan_run;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_hit;
    logic scan_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/nrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// nrg_ctrl
// Request sequencer: evaluate, optional ring scan, apply, and output beat
// handoff.
// ----------------------------------------------------------------------------
module nrg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output nrg_pkg::dp_cmd_t cmd,
  input  nrg_pkg::dp_stat_t stat
);
  import nrg_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL:   state_next = S_DECIDE;
      S_DECIDE: state_next = stat.needs_scan ? S_SCAN : S_APPLY;
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EVAL: begin
        cmd.eval       = 1'b1;
        cmd.scan_clear = 1'b1;
      end
      S_DECIDE: begin
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      S_APPLY: begin
        if (out_free) begin
          cmd.apply      = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/nrg_dp.sv =====
// ----------------------------------------------------------------------------
// nrg_dp
// Session state, counter ring with per-entry valid bits, window compare,
// ring scan and the result registers.
// ----------------------------------------------------------------------------
module nrg_dp #(
  parameter int RING_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [63:0]       cfg_wdata,
  input  logic [2:0]        req_type,
  input  logic [63:0]       nonce_sid,
  input  logic [63:0]       nonce_count,
  input  nrg_pkg::dp_cmd_t  cmd,
  output nrg_pkg::dp_stat_t stat,
  output logic [2:0]        status,
  output logic [63:0]       out_counter,
  output logic              session_cleared,
  output logic              session_active
);
  import nrg_pkg::*;

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

  logic [63:0] cfg_sid;

  logic [2:0]  r_type;
  logic [63:0] r_id;
  logic [63:0] r_cnt;

  logic        active, active_next;
  logic [63:0] highest, highest_next;
  logic [IW-1:0] ptr, ptr_next;
  logic [1:0]  fcount, fcount_next;
  logic [63:0] send, send_next;

  logic [63:0] ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;

  logic        id_ok, win_ok, below, above;
  logic [63:0] win_sum;

  logic [IW-1:0] scan_idx;
  logic        issued_all;
  logic [63:0] rd_data;
  logic        rd_vld;
  logic        rd_live;
  logic        rd_last;
  logic        found;
  logic        hit;

  logic        clr, wr, fail;
  logic [2:0]  st_v;
  logic [63:0] ctr_v;
  logic        cleared_v;

  always_ff @(posedge clk) begin
    if (rst) cfg_sid <= '0;
    else if (cfg_we) cfg_sid <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_type <= req_type;
      r_id   <= nonce_sid;
      r_cnt  <= nonce_count;
    end
  end

  // window: (cnt - highest + 32) mod 2^64 must not exceed 64
  assign win_sum = r_cnt - highest + WIN_HALF;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      id_ok  <= (r_id == cfg_sid);
      win_ok <= (win_sum <= WIN_SPAN);
      below  <= (r_cnt < highest);
      above  <= (r_cnt > highest);
    end
  end

  assign stat.needs_scan = (r_type == REQ_CHECK) && active && id_ok && win_ok && below;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      issued_all <= 1'b0;
      rd_live    <= 1'b0;
      rd_last    <= 1'b0;
      found      <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_idx   <= '0;
      issued_all <= 1'b0;
      rd_live    <= 1'b0;
      rd_last    <= 1'b0;
      found      <= 1'b0;
    end else begin
      found <= found || hit;
      if (cmd.scan_run && !issued_all) begin
        rd_live    <= 1'b1;
        rd_last    <= (scan_idx == LAST_IDX);
        issued_all <= (scan_idx == LAST_IDX);
        scan_idx   <= scan_idx + 1'b1;
      end else begin
        rd_live <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run && !issued_all) begin
      rd_data <= ring[scan_idx];
      rd_vld  <= vld[scan_idx];
    end
  end

  assign hit            = rd_live && ((rd_vld ? rd_data : 64'd0) == r_cnt);
  assign stat.scan_hit  = hit;
  assign stat.scan_done = rd_live && rd_last;

  always_comb begin
    active_next  = active;
    highest_next = highest;
    ptr_next     = ptr;
    fcount_next  = fcount;
    send_next    = send;
    clr          = 1'b0;
    wr           = 1'b0;
    fail         = 1'b0;
    st_v         = ST_OK;
    ctr_v        = '0;
    cleared_v    = 1'b0;

    if (r_type == REQ_START) begin
      clr = 1'b1;
    end else if (r_type inside {REQ_CHECK, REQ_DFAIL, REQ_DOK, REQ_ISSUE}) begin
      if (!active) begin
        st_v = ST_NO_SESSION;
      end else begin
        case (r_type)
          REQ_CHECK: begin
            if (!id_ok)      st_v = ST_ID_MISMATCH;
            else if (!win_ok) st_v = ST_WINDOW;
            else if (found)  st_v = ST_REPLAY;
            if (st_v == ST_OK) begin
              wr = 1'b1;
              if (above) highest_next = r_cnt;
              ptr_next = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          REQ_DFAIL: fail = 1'b1;
          REQ_DOK:   fcount_next = '0;
          REQ_ISSUE: begin
            ctr_v     = send;
            send_next = send + 64'd1;
            if (send_next == 64'd0) begin
              clr       = 1'b1;
              cleared_v = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (fail) begin
      if (fcount == FAIL_LAST) begin
        clr       = 1'b1;
        cleared_v = 1'b1;
      end else begin
        fcount_next = fcount + 2'd1;
      end
    end

    if (clr) begin
      active_next  = 1'b0;
      highest_next = '0;
      ptr_next     = '0;
      fcount_next  = '0;
      send_next    = '0;
    end
    if (r_type == REQ_START) active_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      highest <= '0;
      ptr     <= '0;
      fcount  <= '0;
      send    <= '0;
      vld     <= '0;
    end else if (cmd.apply) begin
      active  <= active_next;
      highest <= highest_next;
      ptr     <= ptr_next;
      fcount  <= fcount_next;
      send    <= send_next;
      if (clr)     vld      <= '0;
      else if (wr) vld[ptr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && wr) ring[ptr] <= r_cnt;
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status          <= st_v;
      out_counter     <= ctr_v;
      session_cleared <= cleared_v;
      session_active  <= active_next;
    end
  end

endmodule

// ===== rtl/core/nonce_replay_guard_top.sv =====
// ----------------------------------------------------------------------------
// nonce_replay_guard_top
// Session anti-replay guard for incoming nonces and outgoing nonce counter.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A request passes the EVAL and DECIDE
// states and its result beat is registered in APPLY, which waits while a
// stalled beat still holds the output register; a check of an active session
// whose ID matches and whose counter lies in the window but below the highest
// seen counter also scans the counter ring through its single read port, one
// entry per cycle, stopping early on a match. The result sits in an output
// register, so the next request is taken while a result beat still waits.
// Clearing the session empties the ring at once through per-entry valid bits;
// no clearing pass is needed after reset.
module nonce_replay_guard_top #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [63:0] nonce_sid,
  input  logic [63:0] nonce_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] out_counter,
  output logic        session_cleared,
  output logic        session_active
);
  import nrg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  nrg_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_type         (req_type),
    .nonce_sid        (nonce_sid),
    .nonce_count      (nonce_count),
    .cmd              (cmd),
    .stat             (stat),
    .status           (status),
    .out_counter      (out_counter),
    .session_cleared  (session_cleared),
    .session_active   (session_active)
  );

endmodule

// ===== rtl/core/nrg_checker.sv =====
// ----------------------------------------------------------------------------
// nrg_checker
// Port-level checks for the nonce replay guard, bound to the top level.
// ----------------------------------------------------------------------------
module nrg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [63:0] out_counter,
  input logic        session_cleared,
  input logic        session_active
);
  import nrg_pkg::*;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request beat accepted while another is in flight");

  a_no_session_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_SESSION |-> !session_active && !session_cleared)
    else $error("no-session result shows an active or cleared session");

  a_cleared_inactive: assert property (@(posedge clk) disable iff (rst)
    out_valid && session_cleared |-> !session_active)
    else $error("cleared session still reported active");

  a_counter_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_counter != 64'd0 |-> status == ST_OK)
    else $error("issued counter with non-ok status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_counter))
    else $error("stalled result beat changed");

endmodule

bind nonce_replay_guard_top nrg_checker u_nrg_checker (.*);
